[rtl/core/imp_pkg.sv]
// Shared types and constants for the IQ mean and peak power unit.
package imp_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int DC_W        = 20;
  localparam int DIFF_W      = 21;  // offset-corrected part, 4 fraction bits
  localparam int POWER_W     = 41;  // re^2 + im^2, 8 fraction bits
  localparam int SUM_W       = 58;
  localparam int CNT_W       = 17;
  localparam int MAX_SAMPLES = 65536;
  localparam int STEP_W      = $clog2(SUM_W);
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 88;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DC_REAL = 2'd0,
    CFG_DC_IMAG = 2'd1
  } cfg_reg_e;

  // Divider sequencer, one-hot
  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_e;

  // Frame totals handed from the accumulator to the divider
  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]   count;
    logic [POWER_W-1:0] peak;
    logic               overflow;
  } frame_stat_t;

endpackage

[rtl/core/imp_front.sv]
// Front end: DC removal, power pipeline and per-frame accumulator.
module imp_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [imp_pkg::DC_W-1:0]     dc_real_i,
  input  logic signed [imp_pkg::DC_W-1:0]     dc_imag_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [imp_pkg::SAMPLE_W-1:0] sample_real_i,
  input  logic signed [imp_pkg::SAMPLE_W-1:0] sample_imag_i,
  input  logic                                frame_end_i,
  input  logic                                queue_full_i,
  output logic                                push_o,
  output imp_pkg::frame_stat_t                push_stat_o
);

  logic advance;

  // stage 1: offset-corrected parts
  logic                              s1_valid_q, s1_last_q;
  logic signed [imp_pkg::DIFF_W-1:0] s1_dr_q, s1_di_q, dr_d, di_d;
  // stage 2: squares
  logic                               s2_valid_q, s2_last_q;
  logic [imp_pkg::POWER_W-1:0]        s2_sqr_q, s2_sqi_q;
  logic signed [2*imp_pkg::DIFF_W-1:0] prod_r, prod_i;
  // stage 3: power
  logic                        s3_valid_q, s3_last_q;
  logic [imp_pkg::POWER_W-1:0] s3_pow_q;
  // frame state
  logic [imp_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [imp_pkg::POWER_W-1:0] peak_q, peak_d;
  logic [imp_pkg::CNT_W-1:0]   count_q, count_d;
  logic                        ovf_q, ovf_d;
  logic                        full_frame;

  // Only a frame end that cannot enter the queue holds the pipe.
  assign advance    = !(s3_valid_q && s3_last_q && queue_full_i);
  assign in_ready_o = advance;

  assign dr_d = {sample_real_i[imp_pkg::SAMPLE_W-1], sample_real_i, 4'b0000}
              - {dc_real_i[imp_pkg::DC_W-1], dc_real_i};
  assign di_d = {sample_imag_i[imp_pkg::SAMPLE_W-1], sample_imag_i, 4'b0000}
              - {dc_imag_i[imp_pkg::DC_W-1], dc_imag_i};

  assign prod_r = s1_dr_q * s1_dr_q;
  assign prod_i = s1_di_q * s1_di_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_dr_q   <= dr_d;
      s1_di_q   <= di_d;
      s1_last_q <= frame_end_i;
      s2_sqr_q  <= prod_r[imp_pkg::POWER_W-1:0];
      s2_sqi_q  <= prod_i[imp_pkg::POWER_W-1:0];
      s2_last_q <= s1_last_q;
      s3_pow_q  <= s2_sqr_q + s2_sqi_q;
      s3_last_q <= s2_last_q;
    end
  end

  // Samples past the size limit are dropped but flag the frame.
  assign full_frame = (count_q == imp_pkg::CNT_W'(imp_pkg::MAX_SAMPLES));

  always_comb begin
    sum_d   = sum_q;
    peak_d  = peak_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    if (full_frame) begin
      ovf_d = 1'b1;
    end else begin
      sum_d   = sum_q + imp_pkg::SUM_W'(s3_pow_q);
      peak_d  = (s3_pow_q > peak_q) ? s3_pow_q : peak_q;
      count_d = count_q + 1'b1;
    end
  end

  assign push_o               = advance && s3_valid_q && s3_last_q;
  assign push_stat_o.sum      = sum_d;
  assign push_stat_o.count    = count_d;
  assign push_stat_o.peak     = peak_d;
  assign push_stat_o.overflow = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      peak_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (advance && s3_valid_q) begin
      if (s3_last_q) begin
        sum_q   <= '0;
        peak_q  <= '0;
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        sum_q   <= sum_d;
        peak_q  <= peak_d;
        count_q <= count_d;
        ovf_q   <= ovf_d;
      end
    end
  end

endmodule

[rtl/core/imp_queue.sv]
// Two-entry queue of frame totals between accumulator and divider.
module imp_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  imp_pkg::frame_stat_t push_stat_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  logic                 pop_i,
  output imp_pkg::frame_stat_t stat_o
);

  imp_pkg::frame_stat_t entry_q [2];
  logic                 wr_ptr_q, rd_ptr_q;
  logic [1:0]           fill_q;

  assign full_o  = fill_q[1];
  assign valid_o = (fill_q != 2'd0);
  assign stat_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_stat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

[rtl/core/imp_divider.sv]
// Back end: bit-serial sum/count divider and result register.
module imp_divider (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               stat_valid_i,
  input  imp_pkg::frame_stat_t               stat_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [imp_pkg::POWER_W-1:0]        average_o,
  output logic [imp_pkg::POWER_W-1:0]        peak_o,
  output logic                               overflow_o
);

  imp_pkg::div_state_e         state_q;
  logic [imp_pkg::SUM_W-1:0]   quot_q;
  logic [imp_pkg::CNT_W-1:0]   rem_q, divisor_q;
  logic [imp_pkg::STEP_W-1:0]  step_q;
  logic [imp_pkg::POWER_W-1:0] peak_q;
  logic                        ovf_q;
  logic                        out_valid_q;
  logic [imp_pkg::POWER_W-1:0] out_avg_q, out_peak_q;
  logic                        out_ovf_q;
  logic [imp_pkg::CNT_W:0]     trial;
  logic [imp_pkg::CNT_W:0]     trial_diff;
  logic                        fits;
  logic                        load_out;

  assign pop_o      = (state_q == imp_pkg::DIV_IDLE) && stat_valid_i;
  assign trial      = {rem_q, quot_q[imp_pkg::SUM_W-1]};
  assign fits       = (trial >= {1'b0, divisor_q});
  assign trial_diff = trial - {1'b0, divisor_q};
  assign load_out   = (state_q == imp_pkg::DIV_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imp_pkg::DIV_IDLE;
      step_q  <= '0;
    end else begin
      case (state_q)
        imp_pkg::DIV_IDLE: begin
          if (stat_valid_i) begin
            state_q <= imp_pkg::DIV_RUN;
            step_q  <= '0;
          end
        end
        imp_pkg::DIV_RUN: begin
          step_q <= step_q + 1'b1;
          if (step_q == imp_pkg::STEP_W'(imp_pkg::SUM_W - 1)) begin
            state_q <= imp_pkg::DIV_DONE;
          end
        end
        imp_pkg::DIV_DONE: begin
          if (load_out) state_q <= imp_pkg::DIV_IDLE;
        end
        default: state_q <= imp_pkg::DIV_IDLE;
      endcase
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      quot_q    <= stat_i.sum;
      rem_q     <= '0;
      divisor_q <= stat_i.count;
      peak_q    <= stat_i.peak;
      ovf_q     <= stat_i.overflow;
    end else if (state_q == imp_pkg::DIV_RUN) begin
      quot_q <= {quot_q[imp_pkg::SUM_W-2:0], fits};
      rem_q  <= fits ? trial_diff[imp_pkg::CNT_W-1:0] : trial[imp_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_avg_q  <= quot_q[imp_pkg::POWER_W-1:0];
      out_peak_q <= peak_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = out_avg_q;
  assign peak_o      = out_peak_q;
  assign overflow_o  = out_ovf_q;

  // a frame always holds at least one sample
  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == imp_pkg::DIV_RUN) |-> (divisor_q != '0))
    else $error("divider started with zero sample count");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == imp_pkg::DIV_RUN) |-> (rem_q < divisor_q))
    else $error("partial remainder not below divisor");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == imp_pkg::DIV_DONE && out_valid_q && !out_ready_i)
      |=> (state_q == imp_pkg::DIV_DONE))
    else $error("finished quotient dropped while result stalled");

endmodule

[rtl/core/iq_mean_and_peak_power_unit.sv]
// Top level of the IQ mean and peak power unit.
//
// Usage:
//  - s_axis carries one complex sample per transfer: tdata holds the real part
//    in [15:0] and the imaginary part in [31:16]; tlast marks the frame's last
//    sample. Samples are taken one per cycle while tready is high.
//  - m_axis carries one result per frame: tdata holds the mean power in [40:0]
//    and the peak power in [81:41] (both 8 fraction bits); tuser[0] is set when
//    the frame held more than 65536 samples (the excess is ignored).
//  - cfg writes the DC offsets (index 0 real, 1 imaginary, 20-bit signed with
//    4 fraction bits). Write only while no frame is in flight.
// Path: after the tlast transfer the frame end passes two more pipeline stages,
// enters the queue, starts the divider once it is free, runs all 58 quotient
// bits of the bit-serial divider and is loaded into the output register.
// Throughput: one sample per cycle while tready is high; the divider takes
// new frame totals only once idle again. A two-entry queue of frame totals
// lets the accumulator run on; tready drops only when a frame end meets a
// full queue. A stalled m_axis holds the result and backs up into the queue.
// Reset clears offsets, frame totals, queue and all valid flags.
module iq_mean_and_peak_power_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // sample_real [15:0], sample_imag [31:16]
  input  logic [imp_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
  input  logic                                  s_axis_tlast,   // frame_end
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // average_power [40:0], peak_power [81:41], zero [87:82]
  output logic [imp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
  output logic [0:0]                            m_axis_tuser,   // overflow [0]
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [imp_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [imp_pkg::DC_W-1:0]              cfg_data_i
);

  logic signed [imp_pkg::DC_W-1:0] dc_real_q, dc_imag_q;
  logic                            push, queue_full, stat_valid, pop;
  imp_pkg::frame_stat_t            push_stat, head_stat;
  logic [imp_pkg::POWER_W-1:0]     average, peak;
  logic                            overflow;

  // Config registers; writes always accepted.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_real_q <= '0;
      dc_imag_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        imp_pkg::CFG_DC_REAL: dc_real_q <= cfg_data_i;
        imp_pkg::CFG_DC_IMAG: dc_imag_q <= cfg_data_i;
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  imp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dc_real_i     (dc_real_q),
    .dc_imag_i     (dc_imag_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .sample_real_i (s_axis_tdata[15:0]),
    .sample_imag_i (s_axis_tdata[31:16]),
    .frame_end_i   (s_axis_tlast),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .push_stat_o   (push_stat)
  );

  imp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_stat_i (push_stat),
    .full_o      (queue_full),
    .valid_o     (stat_valid),
    .pop_i       (pop),
    .stat_o      (head_stat)
  );

  imp_divider u_divider (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stat_valid_i (stat_valid),
    .stat_i       (head_stat),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .average_o    (average),
    .peak_o       (peak),
    .overflow_o   (overflow)
  );

  assign m_axis_tdata = {6'b0, peak, average};
  assign m_axis_tuser = overflow;

endmodule
